>>> sv/rsv_pkg.sv
// Package for the replay stream validator: types, codes and the file signature.
`default_nettype none

package rsv_pkg;

    localparam int unsigned HDR_BYTES   = 36;
    localparam int unsigned HDR_WORDS_END = 28;
    localparam logic [31:0] FRAME_LIMIT_RST = 32'd1048576;
    localparam logic [31:0] MAX_LEVEL   = 32'd19;
    localparam logic [31:0] MAX_HEIGHT  = 32'd5;
    localparam logic [31:0] HDR_VERSION = 32'd1;

    localparam logic [7:0] SIG_BYTES [8] = '{8'h54, 8'h54, 8'h52, 8'h50,
                                            8'h4c, 8'h59, 8'h30, 8'h31};

    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_HDR   = 3'd1,
        PH_FRM   = 3'd2,
        PH_TAIL  = 3'd3,
        PH_DRAIN = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SIGNATURE = 3'd0,
        ERR_HEADER    = 3'd1,
        ERR_LIMITS    = 3'd2,
        ERR_FRAMES    = 3'd3,
        ERR_TRAILING  = 3'd4
    } err_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_EOF  = 1'b1
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] seed;
        logic        mode_b;
        logic [4:0]  init_level;
        logic [2:0]  init_height;
        logic        preview_flag;
        logic [31:0] frame_total;
        logic [63:0] end_hash;
        logic [31:0] frame_index;
        logic [8:0]  frame_mask;
        logic [2:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

>>> sv/replay_stream_validator.sv
// Replay stream validator top level: byte parser, header checks and result buffering.
`default_nettype none

// Takes one word per cycle while item_stall is low (a file byte or an end-of-file
// marker) and parses the replay file in a single pass with no frame storage. A
// result that a word causes is registered in the output register, or in the skid
// entry if the output register is full and not taken. Results go through an output
// register backed by one skid entry, so input is accepted every cycle while the
// consumer keeps up; item_stall rises only when the skid entry is occupied. frame_limit
// may be written over the cfg channel, which is always ready, while the parser is idle.
module replay_stream_validator
    import rsv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  data_byte,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       result_kind,
    output logic [31:0]      seed,
    output logic             mode_b,
    output logic [4:0]       init_level,
    output logic [2:0]       init_height,
    output logic             preview_flag,
    output logic [31:0]      frame_total,
    output logic [63:0]      end_hash,
    output logic [31:0]      frame_index,
    output logic [8:0]       frame_mask,
    output logic [2:0]       error_code
);

    logic [31:0] frame_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] held_seed_reg, held_seed_next;
    logic        held_mode_reg, held_mode_next;
    logic [4:0]  held_level_reg, held_level_next;
    logic [2:0]  held_height_reg, held_height_next;
    logic        held_peek_reg, held_peek_next;
    logic [31:0] held_count_reg, held_count_next;
    logic [31:0] frames_seen_reg, frames_seen_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic        fault_reg, fault_next;

    logic        res_valid;
    result_t     res;

    logic        out_valid_reg, skid_valid_reg;
    result_t     out_reg, skid_reg;

    logic        accept;
    logic        out_fire;

    assign cfg_ready  = 1'b1;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;
    assign out_fire   = out_valid_reg && !result_stall;

    always_comb
    begin
        logic [2:0]  k;
        logic [5:0]  pos_inc;
        logic [31:0] v;
        logic [31:0] seen_inc;
        pos_inc  = pos_reg + 6'd1;
        seen_inc = frames_seen_reg + 32'd1;
        k        = (pos_reg < 6'(HDR_WORDS_END)) ? {1'b0, pos_reg[1:0]}
                                                 : 3'(pos_reg - 6'(HDR_WORDS_END));
        v        = '0;

        phase_next       = phase_reg;
        pos_next         = pos_reg;
        acc_next         = acc_reg;
        held_seed_next   = held_seed_reg;
        held_mode_next   = held_mode_reg;
        held_level_next  = held_level_reg;
        held_height_next = held_height_reg;
        held_peek_next   = held_peek_reg;
        held_count_next  = held_count_reg;
        frames_seen_next = frames_seen_reg;
        low_byte_next    = low_byte_reg;
        fault_next       = fault_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (accept)
        begin
            if (req_type == REQ_EOF)
            begin
                res_valid = 1'b1;
                res.result_kind = KIND_ERROR;
                case (phase_reg)
                    PH_SIG:  res.error_code = ERR_SIGNATURE;
                    PH_HDR:  res.error_code = ERR_HEADER;
                    PH_FRM:  res.error_code = ERR_FRAMES;
                    PH_TAIL: res.result_kind = KIND_DONE;
                    default: res_valid = 1'b0;
                endcase
                phase_next       = PH_SIG;
                pos_next         = '0;
                acc_next         = '0;
                held_seed_next   = '0;
                held_mode_next   = 1'b0;
                held_level_next  = '0;
                held_height_next = '0;
                held_peek_next   = 1'b0;
                held_count_next  = '0;
                frames_seen_next = '0;
                low_byte_next    = '0;
                fault_next       = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_SIG:
                    begin
                        if (data_byte != SIG_BYTES[pos_reg[2:0]])
                        begin
                            res_valid = 1'b1;
                            res.result_kind = KIND_ERROR;
                            res.error_code = ERR_SIGNATURE;
                            phase_next = PH_DRAIN;
                            pos_next   = '0;
                        end
                        else if (pos_inc >= 6'd8)
                        begin
                            phase_next = PH_HDR;
                            pos_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_HDR:
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            if (3'(i) == k)
                                acc_next[8*i +: 8] = data_byte;
                            else if (k == 3'd0)
                                acc_next[8*i +: 8] = 8'h00;
                        end
                        v = acc_next[31:0];
                        pos_next = pos_inc;
                        if (pos_reg < 6'(HDR_WORDS_END) && k == 3'd3)
                        begin
                            case (pos_reg[4:2])
                                3'd0:
                                begin
                                    if (v != HDR_VERSION)
                                    begin
                                        res_valid = 1'b1;
                                        res.result_kind = KIND_ERROR;
                                        res.error_code = ERR_HEADER;
                                        phase_next = PH_DRAIN;
                                        pos_next   = '0;
                                    end
                                end
                                3'd1: held_seed_next = v;
                                3'd2:
                                begin
                                    if (v > 32'd1) fault_next = 1'b1;
                                    held_mode_next = v[0];
                                end
                                3'd3:
                                begin
                                    if (v > MAX_LEVEL) fault_next = 1'b1;
                                    held_level_next = v[4:0];
                                end
                                3'd4:
                                begin
                                    if (v > MAX_HEIGHT) fault_next = 1'b1;
                                    held_height_next = v[2:0];
                                end
                                3'd5:
                                begin
                                    if (v > 32'd1) fault_next = 1'b1;
                                    held_peek_next = v[0];
                                end
                                default: held_count_next = v;
                            endcase
                        end
                        else if (pos_reg == 6'(HDR_BYTES - 1))
                        begin
                            res_valid = 1'b1;
                            pos_next  = '0;
                            if (fault_reg || held_count_reg == 32'd0 ||
                                held_count_reg > frame_limit_reg)
                            begin
                                res.result_kind = KIND_ERROR;
                                res.error_code = ERR_LIMITS;
                                phase_next = PH_DRAIN;
                            end
                            else
                            begin
                                res.result_kind  = KIND_HEADER;
                                res.seed         = held_seed_reg;
                                res.mode_b       = held_mode_reg;
                                res.init_level   = held_level_reg;
                                res.init_height  = held_height_reg;
                                res.preview_flag = held_peek_reg;
                                res.frame_total  = held_count_reg;
                                res.end_hash     = acc_next;
                                phase_next       = PH_FRM;
                                frames_seen_next = '0;
                            end
                        end
                    end
                    PH_FRM:
                    begin
                        if (pos_reg == 6'd0)
                        begin
                            low_byte_next = data_byte;
                            pos_next      = 6'd1;
                        end
                        else
                        begin
                            pos_next  = '0;
                            res_valid = 1'b1;
                            if (data_byte[7:1] != 7'd0)
                            begin
                                res.result_kind = KIND_ERROR;
                                res.error_code = ERR_FRAMES;
                                phase_next = PH_DRAIN;
                            end
                            else
                            begin
                                res.result_kind  = KIND_FRAME;
                                res.frame_index  = frames_seen_reg;
                                res.frame_mask   = {data_byte[0], low_byte_reg};
                                frames_seen_next = seen_inc;
                                if (seen_inc == held_count_reg)
                                    phase_next = PH_TAIL;
                            end
                        end
                    end
                    PH_TAIL:
                    begin
                        res_valid = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code = ERR_TRAILING;
                        phase_next = PH_DRAIN;
                        pos_next   = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= FRAME_LIMIT_RST;
            phase_reg       <= PH_SIG;
            pos_reg         <= '0;
            acc_reg         <= '0;
            held_seed_reg   <= '0;
            held_mode_reg   <= 1'b0;
            held_level_reg  <= '0;
            held_height_reg <= '0;
            held_peek_reg   <= 1'b0;
            held_count_reg  <= '0;
            frames_seen_reg <= '0;
            low_byte_reg    <= '0;
            fault_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frame_limit_reg <= cfg_data;
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            acc_reg         <= acc_next;
            held_seed_reg   <= held_seed_next;
            held_mode_reg   <= held_mode_next;
            held_level_reg  <= held_level_next;
            held_height_reg <= held_height_next;
            held_peek_reg   <= held_peek_next;
            held_count_reg  <= held_count_next;
            frames_seen_reg <= frames_seen_next;
            low_byte_reg    <= low_byte_next;
            fault_reg       <= fault_next;
        end
    end

    // output register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = out_reg.result_kind;
    assign seed         = out_reg.seed;
    assign mode_b       = out_reg.mode_b;
    assign init_level   = out_reg.init_level;
    assign init_height  = out_reg.init_height;
    assign preview_flag = out_reg.preview_flag;
    assign frame_total  = out_reg.frame_total;
    assign end_hash     = out_reg.end_hash;
    assign frame_index  = out_reg.frame_index;
    assign frame_mask   = out_reg.frame_mask;
    assign error_code   = out_reg.error_code;

endmodule

`default_nettype wire

>>> tb/sv/tb_replay_stream_validator.sv
// Self-checking testbench for replay_stream_validator: replay files in, checked results out.
import rsv_pkg::*;

class replay_expectations;
    logic [31:0] frame_limit;
    phase_t      phase;
    logic [5:0]  pos;
    logic [63:0] acc;
    logic [31:0] seed_q;
    logic        mode_q;
    logic [4:0]  level_q;
    logic [2:0]  height_q;
    logic        show_q;
    logic [31:0] count_q;
    logic [31:0] frames_q;
    logic [7:0]  low_byte;
    bit          range_fault;
    result_t     expected_results[$];
    int          mismatches;

    function new();
        frame_limit = FRAME_LIMIT_RST;
        mismatches  = 0;
        clear_parser();
    endfunction

    function void clear_parser();
        phase       = PH_SIG;
        pos         = '0;
        acc         = '0;
        seed_q      = '0;
        mode_q      = 1'b0;
        level_q     = '0;
        height_q    = '0;
        show_q      = 1'b0;
        count_q     = '0;
        frames_q    = '0;
        low_byte    = '0;
        range_fault = 1'b0;
    endfunction

    function result_t abort_file(input err_t code);
        result_t r;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.error_code  = code;
        phase = PH_DRAIN;
        pos   = '0;
        return r;
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    // Next state and expected result for one accepted word.
    function void note_word(input req_t req, input logic [7:0] b);
        result_t     r;
        bit          emit;
        logic [5:0]  at;
        int unsigned k;
        logic [31:0] v;
        logic [15:0] mask;
        r    = '0;
        emit = 1'b0;
        if (req == REQ_EOF) begin
            emit = 1'b1;
            case (phase)
                PH_SIG:  begin r.result_kind = KIND_ERROR; r.error_code = ERR_SIGNATURE; end
                PH_HDR:  begin r.result_kind = KIND_ERROR; r.error_code = ERR_HEADER; end
                PH_FRM:  begin r.result_kind = KIND_ERROR; r.error_code = ERR_FRAMES; end
                PH_TAIL: r.result_kind = KIND_DONE;
                default: emit = 1'b0;
            endcase
            clear_parser();
        end
        else begin
            case (phase)
                PH_SIG:
                begin
                    if (b != SIG_BYTES[pos[2:0]])
                    begin
                        r = abort_file(ERR_SIGNATURE);
                        emit = 1'b1;
                    end
                    else
                    begin
                        pos = pos + 1'b1;
                        if (pos >= 6'd8)
                        begin
                            phase = PH_HDR;
                            pos   = '0;
                        end
                    end
                end
                PH_HDR:
                begin
                    at = pos;
                    k  = (at < HDR_WORDS_END) ? at[1:0] : at - HDR_WORDS_END;
                    if (k == 0)
                        acc = '0;
                    acc = acc | ({56'd0, b} << (8 * k));
                    pos = at + 1'b1;
                    if (at < HDR_WORDS_END && k == 3)
                    begin
                        v = acc[31:0];
                        case (at >> 2)
                            0:
                            begin
                                if (v != HDR_VERSION)
                                begin
                                    r = abort_file(ERR_HEADER);
                                    emit = 1'b1;
                                end
                            end
                            1: seed_q = v;
                            2: begin if (v > 1) range_fault = 1'b1; mode_q = v[0]; end
                            3: begin if (v > MAX_LEVEL) range_fault = 1'b1; level_q = v[4:0]; end
                            4: begin if (v > MAX_HEIGHT) range_fault = 1'b1; height_q = v[2:0]; end
                            5: begin if (v > 1) range_fault = 1'b1; show_q = v[0]; end
                            default: count_q = v;
                        endcase
                    end
                    else if (at == HDR_BYTES - 1)
                    begin
                        emit = 1'b1;
                        if (range_fault || count_q == 0 || count_q > frame_limit)
                            r = abort_file(ERR_LIMITS);
                        else
                        begin
                            r.result_kind  = KIND_HEADER;
                            r.seed         = seed_q;
                            r.mode_b       = mode_q;
                            r.init_level   = level_q;
                            r.init_height  = height_q;
                            r.preview_flag = show_q;
                            r.frame_total  = count_q;
                            r.end_hash     = acc;
                            phase    = PH_FRM;
                            pos      = '0;
                            frames_q = '0;
                        end
                    end
                end
                PH_FRM:
                begin
                    if (pos == 0)
                    begin
                        low_byte = b;
                        pos = 6'd1;
                    end
                    else
                    begin
                        pos  = '0;
                        mask = {b, low_byte};
                        emit = 1'b1;
                        if (mask[15:9] != 0)
                            r = abort_file(ERR_FRAMES);
                        else
                        begin
                            r.result_kind = KIND_FRAME;
                            r.frame_index = frames_q;
                            r.frame_mask  = mask[8:0];
                            frames_q = frames_q + 1;
                            if (frames_q == count_q)
                                phase = PH_TAIL;
                        end
                    end
                end
                PH_TAIL:
                begin
                    r = abort_file(ERR_TRAILING);
                    emit = 1'b1;
                end
                default: ;
            endcase
        end
        if (emit)
            expected_results.push_back(r);
    endfunction

    task report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task compare_field(input string fname, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", fname, got, want));
    endtask

    task check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d", got.result_kind));
            return;
        end
        want = expected_results.pop_front();
        compare_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
        compare_field("seed", 64'(got.seed), 64'(want.seed));
        compare_field("mode_b", 64'(got.mode_b), 64'(want.mode_b));
        compare_field("init_level", 64'(got.init_level), 64'(want.init_level));
        compare_field("init_height", 64'(got.init_height), 64'(want.init_height));
        compare_field("preview_flag", 64'(got.preview_flag), 64'(want.preview_flag));
        compare_field("frame_total", 64'(got.frame_total), 64'(want.frame_total));
        compare_field("end_hash", got.end_hash, want.end_hash);
        compare_field("frame_index", 64'(got.frame_index), 64'(want.frame_index));
        compare_field("frame_mask", 64'(got.frame_mask), 64'(want.frame_mask));
        compare_field("error_code", 64'(got.error_code), 64'(want.error_code));
    endtask
endclass

module tb_replay_stream_validator;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        req_type = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [31:0] seed;
    logic        mode_b;
    logic [4:0]  init_level;
    logic [2:0]  init_height;
    logic        preview_flag;
    logic [31:0] frame_total;
    logic [63:0] end_hash;
    logic [31:0] frame_index;
    logic [8:0]  frame_mask;
    logic [2:0]  error_code;

    replay_expectations sb = new();
    logic [7:0] file_bytes[$];
    int         words_sent = 0;
    int         burst_left = 0;
    bit         hold_req = 1'b0;

    replay_stream_validator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req_type     (req_type),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .seed         (seed),
        .mode_b       (mode_b),
        .init_level   (init_level),
        .init_height  (init_height),
        .preview_flag (preview_flag),
        .frame_total  (frame_total),
        .end_hash     (end_hash),
        .frame_index  (frame_index),
        .frame_mask   (frame_mask),
        .error_code   (error_code)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got.result_kind  = result_kind;
                got.seed         = seed;
                got.mode_b       = mode_b;
                got.init_level   = init_level;
                got.init_height  = init_height;
                got.preview_flag = preview_flag;
                got.frame_total  = frame_total;
                got.end_hash     = end_hash;
                got.frame_index  = frame_index;
                got.frame_mask   = frame_mask;
                got.error_code   = error_code;
                sb.check_result(got);
            end
            if (item_valid && !item_stall)
                sb.note_word(req_t'(req_type), data_byte);
        end
    end

    // Receiver: segments of free flow, light or heavy random stall, a fixed pattern,
    // and a long hold-off on request.
    initial
    begin : rx_pattern
        int seg;
        int style;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                repeat (300)
                begin
                    @(posedge clk);
                    result_stall <= 1'b1;
                end
                hold_req = 1'b0;
            end
            seg   = $urandom_range(10, 120);
            style = $urandom_range(0, 3);
            for (int n = 0; n < seg; n++)
            begin
                @(posedge clk);
                case (style)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= (n % 4 == 1);
                endcase
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    task send_word(input req_t req, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        item_valid <= 1'b1;
        req_type   <= req;
        data_byte  <= b;
        burst_left--;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task wait_drained();
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_frame_limit(input logic [31:0] v);
        item_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.frame_limit = v;
    endtask

    task push_u32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endtask

    task push_u16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task build_header(input logic [31:0] ver, input logic [31:0] sd, input logic [31:0] md,
                      input logic [31:0] lv, input logic [31:0] ht, input logic [31:0] sn,
                      input logic [31:0] cnt, input logic [63:0] hsh);
        file_bytes.delete();
        for (int i = 0; i < 8; i++)
            file_bytes.push_back(SIG_BYTES[i]);
        push_u32(ver);
        push_u32(sd);
        push_u32(md);
        push_u32(lv);
        push_u32(ht);
        push_u32(sn);
        push_u32(cnt);
        push_u32(hsh[31:0]);
        push_u32(hsh[63:32]);
    endtask

    task trim_to(input int n);
        while (file_bytes.size() > n)
            void'(file_bytes.pop_back());
    endtask

    task play_file();
        foreach (file_bytes[i])
            send_word(REQ_BYTE, file_bytes[i]);
        send_word(REQ_EOF, 8'($urandom_range(0, 255)));
    endtask

    task random_file();
        logic [31:0] lim;
        logic [31:0] cnt;
        logic [31:0] ver;
        logic [31:0] md;
        logic [31:0] lv;
        logic [31:0] ht;
        logic [31:0] sn;
        int          nfr;
        int          cut;
        lim = sb.frame_limit;
        case ($urandom_range(0, 19))
            0: cnt = '0;
            1: cnt = lim;
            2: cnt = lim + 1;
            default: cnt = $urandom_range(1, (lim < 6) ? lim : 6);
        endcase
        ver = HDR_VERSION;
        md  = $urandom_range(0, 1);
        lv  = $urandom_range(0, MAX_LEVEL);
        ht  = $urandom_range(0, MAX_HEIGHT);
        sn  = $urandom_range(0, 1);
        case ($urandom_range(0, 24))
            0: md = $urandom_range(2, 32'hffff_ffff);
            1: lv = $urandom_range(20, 32'hffff_ffff);
            2: ht = $urandom_range(6, 32'hffff_ffff);
            3: sn = $urandom_range(2, 32'hffff_ffff);
            4: ver = $urandom;
            default: ;
        endcase
        build_header(ver, $urandom, md, lv, ht, sn, cnt, {$urandom, $urandom});
        nfr = (cnt <= 6) ? cnt : $urandom_range(0, 3);
        for (int i = 0; i < nfr; i++)
            push_u16(($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 511)));
        case ($urandom_range(0, 9))
            0: trim_to($urandom_range(0, file_bytes.size() - 1));
            1:
            begin
                cut = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
            end
            2:
                repeat ($urandom_range(1, 3))
                    file_bytes.push_back(8'($urandom_range(0, 255)));
            3:
            begin
                file_bytes.delete();
                if ($urandom_range(0, 1))
                    file_bytes.push_back(SIG_BYTES[0]);
                repeat ($urandom_range(1, 12))
                    file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        play_file();
    endtask

    initial
    begin : stimulus
        int file_no;
        logic [31:0] new_limit;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_frame_limit(FRAME_LIMIT_RST);
        file_bytes.delete();
        play_file();
        build_header(HDR_VERSION, '1, 1, MAX_LEVEL, MAX_HEIGHT, 1, 1, '1);
        push_u16(16'h01ff);
        play_file();
        build_header(HDR_VERSION, 0, 0, 0, 0, 0, 2, 0);
        push_u16(16'h0000);
        push_u16(16'h00aa);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 1, 1, 0, 1, 64'h1);
        file_bytes[3] = 8'h00;
        play_file();
        build_header(32'd2, $urandom, 0, 1, 1, 0, 1, 0);
        play_file();
        build_header(32'h0100_0001, $urandom, 0, 1, 1, 0, 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 1, 1, 0, 1, 0);
        trim_to(20);
        play_file();
        trim_to(8);
        play_file();
        trim_to(5);
        play_file();
        build_header(HDR_VERSION, $urandom, 2, 3, 2, 1, 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 20, 2, 1, 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 3, 6, 1, 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 3, 2, 2, 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 3, 2, 1, 0, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 3, 2, 1, FRAME_LIMIT_RST + 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 1, '1, 2, 1, 1, 0);
        play_file();
        build_header(HDR_VERSION, $urandom, 1, 7, 3, 0, FRAME_LIMIT_RST, {$urandom, $urandom});
        push_u16(16'h0005);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 4, 0, 1, 2, 0);
        push_u16(16'h0003);
        push_u16(16'h0200);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 4, 0, 1, 1, 0);
        push_u16(16'hfe00);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 4, 0, 1, 1, 0);
        file_bytes.push_back(8'h12);
        play_file();
        build_header(HDR_VERSION, $urandom, 1, 9, 4, 0, 1, 0);
        push_u16(16'h01ff);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(8'h00);
        play_file();

        write_frame_limit(32'd1);
        build_header(HDR_VERSION, $urandom, 0, 2, 1, 0, 1, 0);
        push_u16(16'h0100);
        play_file();
        build_header(HDR_VERSION, $urandom, 0, 2, 1, 0, 2, 0);
        play_file();
        write_frame_limit(32'hffff_ffff);
        build_header(HDR_VERSION, $urandom, 0, 2, 1, 0, 32'hffff_ffff, '1);
        push_u16(16'h0100);
        play_file();

        file_no = 0;
        while (words_sent < 1100)
        begin
            if (file_no % 5 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: new_limit = 32'd1;
                    1: new_limit = 32'hffff_ffff;
                    2: new_limit = FRAME_LIMIT_RST;
                    3: new_limit = $urandom_range(1, 6);
                    default: new_limit = $urandom_range(1, 32'hffff_ffff);
                endcase
                write_frame_limit(new_limit);
            end
            if (file_no == 2 || file_no == 17)
                hold_req = 1'b1;
            random_file();
            file_no++;
        end
        item_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
sv/rsv_pkg.sv
sv/replay_stream_validator.sv
tb/sv/tb_replay_stream_validator.sv
